### hw/rtl/ltnr_pkg.sv
// Package with shared constants, types and the 5x7 font table of the LCD text renderer.
package ltnr_pkg;

    localparam int MAX_FIELD_WIDTH = 7;
    localparam int MAX_DIGITS = 5;

    localparam logic [1:0] MODE_CHAR = 2'd0;
    localparam logic [1:0] MODE_UNSIGNED = 2'd1;
    localparam logic [1:0] MODE_SIGNED = 2'd2;

    localparam logic [7:0] ROW_CMD = 8'h40;
    localparam logic [7:0] COL_CMD = 8'h80;
    localparam logic [7:0] CODE_SPACE = 8'h20;
    localparam logic [7:0] CODE_MINUS = 8'h2D;
    localparam logic [7:0] CODE_ZERO = 8'h30;
    localparam logic [7:0] CODE_LAST = 8'h7F;
    localparam logic [7:0] INV_MASK = 8'hFF;
    localparam logic [3:0] DIVISOR = 4'd10;
    localparam logic [15:0] RECIP_10 = 16'd52429;
    localparam int RECIP_SHIFT = 19;

    typedef struct packed {
        logic        done;
        logic [15:0] quo;
        logic [3:0]  rem;
    } div_res_t;

    // One glyph per entry, first column in the top byte.
    localparam logic [39:0] FONT_ROM [0:95] = '{
        40'h0000000000, 40'h00005f0000, 40'h0007000700, 40'h147f147f14,
        40'h242a7f2a12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
        40'h001c224100, 40'h0041221c00, 40'h14083e0814, 40'h08083e0808,
        40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
        40'h3e5149453e, 40'h00427f4000, 40'h4261514946, 40'h2141454b31,
        40'h1814127f10, 40'h2745454539, 40'h3c4a494930, 40'h0171090503,
        40'h3649494936, 40'h064949291e, 40'h0036360000, 40'h0056360000,
        40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
        40'h324979413e, 40'h7e1111117e, 40'h7f49494936, 40'h3e41414122,
        40'h7f4141221c, 40'h7f49494941, 40'h7f09090901, 40'h3e4149497a,
        40'h7f0808087f, 40'h00417f4100, 40'h2040413f01, 40'h7f08142241,
        40'h7f40404040, 40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e,
        40'h7f09090906, 40'h3e4151215e, 40'h7f09192946, 40'h4649494931,
        40'h01017f0101, 40'h3f4040403f, 40'h1f2040201f, 40'h3f4038403f,
        40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007f414100,
        40'h0204081020, 40'h0041417f00, 40'h0402010204, 40'h4040404040,
        40'h0001020400, 40'h2054545478, 40'h7f48444438, 40'h3844444420,
        40'h384444487f, 40'h3854545418, 40'h087e090102, 40'h0c5252523e,
        40'h7f08040478, 40'h00447d4000, 40'h2040443d00, 40'h7f10284400,
        40'h00417f4000, 40'h7c04180478, 40'h7c08040478, 40'h3844444438,
        40'h7c14141408, 40'h081414187c, 40'h7c08040408, 40'h4854545420,
        40'h043f444020, 40'h3c4040207c, 40'h1c2040201c, 40'h3c4030403c,
        40'h4428102844, 40'h0c5050503c, 40'h4464544c44, 40'h0008364100,
        40'h00007f0000, 40'h0041360800, 40'h1008081008, 40'h7846414678
    };

endpackage

### hw/rtl/ltnr_if.sv
// Request and byte stream channel interfaces of the LCD text renderer.
interface ltnr_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [7:0]  char_code;
    logic [15:0] number;
    logic [2:0]  row;
    logic [3:0]  column;
    logic [2:0]  field_width;
    logic        invert;
    modport source (output valid, mode, char_code, number, row, column, field_width, invert,
                    input ready);
    modport sink (input valid, mode, char_code, number, row, column, field_width, invert,
                  output ready);
endinterface

interface ltnr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] lcd_byte;
    logic       is_data;
    logic       last;
    modport source (output valid, lcd_byte, is_data, last, input ready);
    modport sink (input valid, lcd_byte, is_data, last, output ready);
endinterface

### hw/rtl/ltnr_div10.sv
// Divide-by-ten unit by reciprocal multiplication; registers the quotient, then the remainder.
module ltnr_div10 (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [15:0]       din,
    output ltnr_pkg::div_res_t res
);
    import ltnr_pkg::*;

    logic        busy_reg, busy_next;
    logic        step_reg, step_next;
    logic        done_reg, done_next;
    logic [15:0] val_reg, val_next;
    logic [15:0] quo_reg, quo_next;
    logic [3:0]  rem_reg, rem_next;
    logic [31:0] prod;
    logic [15:0] back;

    always_comb
    begin
        prod = {16'd0, val_reg} * {16'd0, RECIP_10};
        back = quo_reg * {12'd0, DIVISOR};
        busy_next = busy_reg;
        step_next = step_reg;
        done_next = 1'b0;
        val_next = val_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = 1'b0;
            val_next = din;
        end
        else if (busy_reg)
        begin
            if (!step_reg)
            begin
                quo_next = 16'(prod >> RECIP_SHIFT);
                step_next = 1'b1;
            end
            else
            begin
                rem_next = 4'(val_reg - back);
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign res.done = done_reg;
    assign res.quo = quo_reg;
    assign res.rem = rem_reg;
endmodule

### hw/rtl/lcd_text_number_renderer.sv
// Top level: sequencer that extracts digits through the divider and emits LCD bytes.
// Throughput: one byte per cycle while emitting, unless the output stalls,
// eight bytes per cell, up to 64 per request.
// A new request is taken once the last byte of the previous one is in the output register.
// Digit extraction runs on a single reciprocal divide-by-ten unit, one digit at a time.
// Reset clears the sequencer and the output valid flag; no memory needs clearing.
module lcd_text_number_renderer (
    input  logic       clk,
    input  logic       rst_n,
    ltnr_req_if.sink   req,
    ltnr_out_if.source rsp
);
    import ltnr_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]  state_reg, state_next;
    logic [1:0]  mode_reg;
    logic [7:0]  code_reg;
    logic [2:0]  row_reg;
    logic [3:0]  col_reg;
    logic [2:0]  width_reg;
    logic        inv_reg;
    logic        neg_reg;
    logic [2:0]  len_reg, len_next;
    logic [3:0]  digits [MAX_DIGITS];
    logic [2:0]  ci_reg, ci_next;
    logic [2:0]  bi_reg, bi_next;
    logic        ovalid_reg, ovalid_next;
    logic [7:0]  obyte_reg;
    logic        odata_reg;
    logic        olast_reg;

    logic        accept;
    logic        div_start;
    logic [15:0] div_din;
    div_res_t    div_res;
    logic [2:0]  fw_sat;
    logic        sgn;
    logic [3:0]  pad;
    logic [3:0]  ncells;
    logic [2:0]  j;
    logic [2:0]  p;
    logic [4:0]  base;
    logic [4:0]  cpos;
    logic [7:0]  code;
    logic [7:0]  code_ok;
    logic [6:0]  goff;
    logic [2:0]  gsel;
    logic [39:0] glyph;
    logic [7:0]  gbyte;
    logic [7:0]  mask;
    logic [7:0]  ebyte;
    logic        edata;
    logic        elast;
    logic        adv;

    ltnr_div10 u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .din   (div_din),
        .res   (div_res)
    );

    assign req.ready = (state_reg == ST_IDLE);
    assign accept = req.valid && req.ready;
    assign fw_sat = (32'(req.field_width) > MAX_FIELD_WIDTH) ?
                    3'(MAX_FIELD_WIDTH) : req.field_width;

    always_comb
    begin
        sgn = (mode_reg == MODE_SIGNED);
        pad = ({1'b0, width_reg} > {1'b0, len_reg}) ? 4'({1'b0, width_reg} - {1'b0, len_reg})
                                                    : 4'd0;
        ncells = (mode_reg == MODE_CHAR) ? 4'd1 : 4'({3'd0, sgn} + {1'b0, len_reg} + pad);
        j = ci_reg - {2'd0, sgn};
        p = j - len_reg;
        base = {1'b0, col_reg} + {4'd0, sgn};
        mask = '0;
        if (mode_reg == MODE_CHAR)
        begin
            code = code_reg;
            cpos = {1'b0, col_reg};
            mask = inv_reg ? INV_MASK : 8'h00;
        end
        else if (sgn && ci_reg == 3'd0)
        begin
            code = neg_reg ? CODE_MINUS : CODE_SPACE;
            cpos = {1'b0, col_reg};
        end
        else if (j < len_reg)
        begin
            code = CODE_ZERO + {4'd0, digits[j]};
            cpos = base + {2'd0, len_reg} - 5'd1 - {2'd0, j};
        end
        else
        begin
            code = CODE_SPACE;
            cpos = base + {2'd0, width_reg} - 5'd1 - {2'd0, p};
        end
        code_ok = (code < CODE_SPACE || code > CODE_LAST) ? CODE_SPACE : code;
        goff = 7'(code_ok - CODE_SPACE);
        gsel = (bi_reg >= 3'd2 && bi_reg <= 3'd6) ? 3'(bi_reg - 3'd2) : 3'd0;
        glyph = FONT_ROM[goff];
        case (gsel)
            3'd0:    gbyte = glyph[39:32];
            3'd1:    gbyte = glyph[31:24];
            3'd2:    gbyte = glyph[23:16];
            3'd3:    gbyte = glyph[15:8];
            default: gbyte = glyph[7:0];
        endcase
        case (bi_reg)
            3'd0:    ebyte = ROW_CMD + {5'd0, row_reg};
            3'd1:    ebyte = COL_CMD + {1'b0, cpos, 2'b00} + {2'b00, cpos, 1'b0};
            3'd7:    ebyte = mask;
            default: ebyte = gbyte ^ mask;
        endcase
        edata = (bi_reg >= 3'd2);
        elast = (bi_reg == 3'd7) && ({1'b0, ci_reg} == ncells - 4'd1);
    end

    assign adv = (state_reg == ST_EMIT) && (!ovalid_reg || rsp.ready);

    always_comb
    begin
        state_next = state_reg;
        len_next = len_reg;
        ci_next = ci_reg;
        bi_next = bi_reg;
        ovalid_next = ovalid_reg && !rsp.ready;
        div_start = 1'b0;
        div_din = div_res.quo;
        if (req.number[15] && req.mode == MODE_SIGNED)
        begin
            div_din = 16'(17'h10000 - {1'b0, req.number});
        end
        else if (accept)
        begin
            div_din = req.number;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    len_next = '0;
                    ci_next = '0;
                    bi_next = '0;
                    if (req.mode == MODE_CHAR)
                    begin
                        state_next = ST_EMIT;
                    end
                    else if (req.mode == MODE_UNSIGNED || req.mode == MODE_SIGNED)
                    begin
                        state_next = ST_DIV;
                        div_start = 1'b1;
                    end
                end
            end
            ST_DIV:
            begin
                div_din = div_res.quo;
                if (div_res.done)
                begin
                    len_next = len_reg + 3'd1;
                    if (div_res.quo == 16'd0)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        div_start = 1'b1;
                    end
                end
            end
            ST_EMIT:
            begin
                if (adv)
                begin
                    ovalid_next = 1'b1;
                    bi_next = bi_reg + 3'd1;
                    if (bi_reg == 3'd7)
                    begin
                        ci_next = ci_reg + 3'd1;
                    end
                    if (elast)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ovalid_reg <= 1'b0;
            len_reg <= '0;
            ci_reg <= '0;
            bi_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ovalid_reg <= ovalid_next;
            len_reg <= len_next;
            ci_reg <= ci_next;
            bi_reg <= bi_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= req.mode;
            code_reg <= req.char_code;
            row_reg <= req.row;
            col_reg <= req.column;
            width_reg <= fw_sat;
            inv_reg <= req.invert;
            neg_reg <= req.number[15];
        end
        if (state_reg == ST_DIV && div_res.done)
        begin
            digits[len_reg] <= div_res.rem;
        end
        if (adv)
        begin
            obyte_reg <= ebyte;
            odata_reg <= edata;
            olast_reg <= elast;
        end
    end

    assign rsp.valid = ovalid_reg;
    assign rsp.lcd_byte = obyte_reg;
    assign rsp.is_data = odata_reg;
    assign rsp.last = olast_reg;
endmodule

### hw/rtl/ltnr_checker.sv
// Port-level checker of the LCD text renderer and its bind to the top level.
module ltnr_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       req_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       out_is_data,
    input logic       out_last
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
        else $error("Stalled byte changed.");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_last |-> !req_ready)
        else $error("Request taken in the middle of a byte stream.");

    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !$isunknown({out_byte, out_is_data, out_last}))
        else $error("Valid byte carries unknown bits.");
endmodule

bind lcd_text_number_renderer ltnr_checker u_ltnr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_ready   (req.ready),
    .out_valid   (rsp.valid),
    .out_ready   (rsp.ready),
    .out_byte    (rsp.lcd_byte),
    .out_is_data (rsp.is_data),
    .out_last    (rsp.last)
);
